// ----- hw/rtl/mcs_pkg.sv -----
// Types, register indexes and the microprogram ROM of the motion command smoother.
// Used by motion_command_smoother; depends on nothing else.
package mcs_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChWidth     = 2;
  localparam int unsigned StepWidth   = 4;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN     = 3'd0;
  localparam logic [2:0] REG_DEADBAND = 3'd1;
  localparam logic [2:0] REG_SCALE_FW = 3'd2;
  localparam logic [2:0] REG_SCALE_SW = 3'd3;
  localparam logic [2:0] REG_SCALE_TN = 3'd4;
  localparam logic [2:0] REG_SCALE_PT = 3'd5;
  localparam logic [2:0] REG_DT       = 3'd6;
  localparam logic [2:0] REG_HEIGHT   = 3'd7;

  localparam logic [15:0] GAIN_RESET     = 16'd6554;
  localparam logic [14:0] DEADBAND_RESET = 15'd3277;
  localparam logic [15:0] SCALE_RESET    = 16'd256;
  localparam logic [15:0] DT_RESET       = 16'd655;

  // channel codes
  localparam logic [ChWidth-1:0] CH_FW = 2'd0;
  localparam logic [ChWidth-1:0] CH_SW = 2'd1;
  localparam logic [ChWidth-1:0] CH_TN = 2'd2;
  localparam logic [ChWidth-1:0] CH_PT = 2'd3;

  localparam logic [StepWidth-1:0] STEP_IDLE = 4'd0;
  localparam logic [StepWidth-1:0] STEP_LAST = 4'd13;

  // multiplier operation; the matching write-back runs in the following cycle
  typedef enum logic [1:0] {
    MUL_NONE  = 2'd0,
    MUL_FILT  = 2'd1,
    MUL_SCALE = 2'd2,
    MUL_STEP  = 2'd3
  } mul_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_WAIT_IN  = 2'd1,
    SEQ_WAIT_OUT = 2'd2
  } seq_op_t;

  typedef struct packed {
    mul_op_t             mul_op;
    logic [ChWidth-1:0]  ch;
    seq_op_t             seq;
  } ucode_t;

  // Microprogram. Multiplies are ordered so that each one finds its operand
  // already written back by an earlier step.
  function automatic ucode_t ucode_rom(input logic [StepWidth-1:0] step);
    ucode_t w;
    w = '{mul_op: MUL_NONE, ch: CH_FW, seq: SEQ_NEXT};
    unique case (step)
      4'd0:  w = '{mul_op: MUL_NONE,  ch: CH_FW, seq: SEQ_WAIT_IN};
      4'd1:  w = '{mul_op: MUL_FILT,  ch: CH_FW, seq: SEQ_NEXT};
      4'd2:  w = '{mul_op: MUL_FILT,  ch: CH_SW, seq: SEQ_NEXT};
      4'd3:  w = '{mul_op: MUL_SCALE, ch: CH_FW, seq: SEQ_NEXT};
      4'd4:  w = '{mul_op: MUL_FILT,  ch: CH_TN, seq: SEQ_NEXT};
      4'd5:  w = '{mul_op: MUL_SCALE, ch: CH_SW, seq: SEQ_NEXT};
      4'd6:  w = '{mul_op: MUL_FILT,  ch: CH_PT, seq: SEQ_NEXT};
      4'd7:  w = '{mul_op: MUL_SCALE, ch: CH_TN, seq: SEQ_NEXT};
      4'd8:  w = '{mul_op: MUL_STEP,  ch: CH_FW, seq: SEQ_NEXT};
      4'd9:  w = '{mul_op: MUL_SCALE, ch: CH_PT, seq: SEQ_NEXT};
      4'd10: w = '{mul_op: MUL_STEP,  ch: CH_SW, seq: SEQ_NEXT};
      4'd11: w = '{mul_op: MUL_STEP,  ch: CH_TN, seq: SEQ_NEXT};
      4'd12: w = '{mul_op: MUL_NONE,  ch: CH_FW, seq: SEQ_NEXT};
      4'd13: w = '{mul_op: MUL_NONE,  ch: CH_FW, seq: SEQ_WAIT_OUT};
      default: w = '{mul_op: MUL_NONE, ch: CH_FW, seq: SEQ_WAIT_OUT};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/motion_command_smoother.sv -----
// Motion command smoother: commands are processed one at a time through the one shared
// 17x25 multiplier that a 14-step microprogram drives through eleven multiplies. A new
// command is taken only while the sequencer is idle; the result register lets the
// sequencer return to idle only once the previous result has been transferred.
// Configuration is written through cfg_write/cfg_index/cfg_data.
// Depends on mcs_pkg.
module motion_command_smoother (
  input  logic          clk,
  input  logic          rst,
  // command: move_forward, move_sideways, turn_command, pitch_command, gait_mode
  input  logic [71:0]   s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // result: velocity_forward, velocity_sideways, step_forward, step_sideways,
  // step_height, yaw_rate, pitch_angle, yaw_step, mode_out
  output logic [263:0]  m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import mcs_pkg::*;

  // configuration
  logic        [15:0] gain;
  logic        [14:0] deadband;
  logic signed [15:0] scale [NumChannels];
  logic        [15:0] dt;
  logic signed [31:0] height;

  // sequencer
  logic [StepWidth-1:0] step;
  logic [StepWidth-1:0] step_next;
  ucode_t               uc;

  // datapath
  logic signed [15:0] x_in [NumChannels];
  logic signed [15:0] y    [NumChannels];
  logic signed [24:0] v    [NumChannels];
  logic signed [31:0] stp  [NumChannels-1];
  logic        [3:0]  current_mode;

  logic signed [16:0] op_a;
  logic signed [24:0] op_b;
  logic signed [16:0] diff;
  logic signed [41:0] prod;
  mul_op_t            wr_op;
  logic [ChWidth-1:0] wr_ch;
  logic signed [15:0] y_q;
  logic               dead_q;
  logic               dead_now;
  logic signed [16:0] y_ext;
  logic signed [16:0] lvl_ext;

  logic signed [41:0] rnd16;
  logic signed [41:0] rnd7;
  logic signed [17:0] y_sum;
  logic signed [15:0] y_clamped;

  logic in_xfer;
  logic out_free;

  assign uc            = ucode_rom(step);
  assign s_axis_tready = (step == STEP_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    step_next = step;
    unique case (uc.seq)
      SEQ_NEXT:     step_next = step + 4'd1;
      SEQ_WAIT_IN:  if (in_xfer) step_next = step + 4'd1;
      SEQ_WAIT_OUT: if (out_free) step_next = STEP_IDLE;
      default:      step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= GAIN_RESET;
      deadband <= DEADBAND_RESET;
      for (int i = 0; i < NumChannels; i++) scale[i] <= SCALE_RESET;
      dt       <= DT_RESET;
      height   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN:     gain     <= cfg_data[15:0];
        REG_DEADBAND: deadband <= cfg_data[14:0];
        REG_SCALE_FW: scale[CH_FW] <= cfg_data[15:0];
        REG_SCALE_SW: scale[CH_SW] <= cfg_data[15:0];
        REG_SCALE_TN: scale[CH_TN] <= cfg_data[15:0];
        REG_SCALE_PT: scale[CH_PT] <= cfg_data[15:0];
        REG_DT:       dt       <= cfg_data[15:0];
        REG_HEIGHT:   height   <= cfg_data;
        default:      height   <= height;
      endcase
    end
  end

  // capture the command
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= '0;
    end else if (in_xfer) begin
      current_mode <= s_axis_tdata[67:64];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_in[CH_FW] <= s_axis_tdata[15:0];
      x_in[CH_SW] <= s_axis_tdata[31:16];
      x_in[CH_TN] <= s_axis_tdata[47:32];
      x_in[CH_PT] <= s_axis_tdata[63:48];
    end
  end

  // multiplier operand selection
  assign diff    = {x_in[uc.ch][15], x_in[uc.ch]} - {y[uc.ch][15], y[uc.ch]};
  assign y_ext   = {y[uc.ch][15], y[uc.ch]};
  assign lvl_ext = {2'b00, deadband};
  assign dead_now = (y_ext < lvl_ext) && (y_ext > -lvl_ext);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (uc.mul_op)
      MUL_FILT: begin
        op_a = {1'b0, gain};
        op_b = {{8{diff[16]}}, diff};
      end
      MUL_SCALE: begin
        op_a = {scale[uc.ch][15], scale[uc.ch]};
        op_b = {{9{y[uc.ch][15]}}, y[uc.ch]};
      end
      MUL_STEP: begin
        op_a = {1'b0, dt};
        op_b = v[uc.ch];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_op <= MUL_NONE;
    end else begin
      wr_op <= uc.mul_op;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= 42'(op_a) * 42'(op_b);
    wr_ch  <= uc.ch;
    y_q    <= y[uc.ch];
    dead_q <= dead_now;
  end

  // round half up
  assign rnd16 = (prod + 42'sd32768) >>> 16;
  assign rnd7  = (prod + 42'sd64) >>> 7;
  assign y_sum = {{2{y_q[15]}}, y_q} + rnd16[17:0];

  always_comb begin
    if (y_sum > 18'sd32767) begin
      y_clamped = 16'sh7FFF;
    end else if (y_sum < -18'sd32768) begin
      y_clamped = 16'sh8000;
    end else begin
      y_clamped = y_sum[15:0];
    end
  end

  // write back the previous cycle's product
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumChannels; i++) y[i] <= '0;
    end else if (wr_op == MUL_FILT) begin
      y[wr_ch] <= y_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_op == MUL_SCALE) begin
      v[wr_ch] <= dead_q ? '0 : rnd7[24:0];
    end
    if (wr_op == MUL_STEP && wr_ch != CH_PT) begin
      stp[wr_ch] <= rnd16[31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (uc.seq == SEQ_WAIT_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.seq == SEQ_WAIT_OUT && out_free) begin
      m_axis_tdata[31:0]    <= {{7{v[CH_FW][24]}}, v[CH_FW]};
      m_axis_tdata[63:32]   <= {{7{v[CH_SW][24]}}, v[CH_SW]};
      m_axis_tdata[95:64]   <= stp[CH_FW];
      m_axis_tdata[127:96]  <= stp[CH_SW];
      m_axis_tdata[159:128] <= height;
      m_axis_tdata[191:160] <= {{7{v[CH_TN][24]}}, v[CH_TN]};
      m_axis_tdata[223:192] <= {{7{v[CH_PT][24]}}, v[CH_PT]};
      m_axis_tdata[255:224] <= stp[CH_TN];
      m_axis_tdata[259:256] <= current_mode;
      m_axis_tdata[263:260] <= 4'd0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> step == 4'd1)
    else $error("sequencer did not start after a command transfer");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_LAST && !m_axis_tvalid) |=> (m_axis_tvalid && step == STEP_IDLE))
    else $error("result not loaded at end of program");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (step != STEP_IDLE) |-> !s_axis_tready)
    else $error("command accepted while sequencer busy");

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("step counter left the program");

endmodule
